// ----- rtl/uv_sphere_point_generator_macros.svh -----
// Assertion macros shared by the UV sphere point generator RTL.
`ifndef UV_SPHERE_POINT_GENERATOR_MACROS_SVH
`define UV_SPHERE_POINT_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define UVS_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("uvs check failed");
`define UVS_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
	else $error("uvs reset check failed");
`else
`define UVS_ASSERT(lbl, prop)
`define UVS_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- rtl/uvs_pkg.sv -----
// Types, constants and helper functions for the UV sphere point generator.
package uvs_pkg;

	localparam int PHASE_BITS = 16;
	localparam int MAX_TESSELLATION = 255;
	localparam int INDEX_LIMIT = 65535;
	localparam int MIN_TESSELLATION = 3;

	localparam logic [PHASE_BITS-1:0] LAT_OFS = PHASE_BITS'(3 << (PHASE_BITS - 2));
	localparam logic [14:0] QUARTER = 15'(1 << (PHASE_BITS - 2));
	localparam logic [13:0] HALF = 14'(1 << (PHASE_BITS - 3));
	localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_ONE = 31'd1073741824;

	localparam int DIV_STAGES = 4;
	localparam int HSTEP_LAT = 3;
	localparam int SIN_STEPS = 7;
	localparam int COS_STEPS = 8;
	localparam int X_DLY = SIN_STEPS * HSTEP_LAT + 1;
	localparam int CS_READY = 3 + COS_STEPS * HSTEP_LAT;
	localparam int S_DLY = CS_READY - (3 + SIN_STEPS * HSTEP_LAT + 1);
	localparam int Q_DLY = CS_READY - 1;
	localparam int SC_LAT = CS_READY + 1;
	localparam int POS_LAT = 2;
	localparam int CORE_LAT = DIV_STAGES + SC_LAT + POS_LAT;
	localparam int IDX_DLY = CORE_LAT - 1;

	localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd210, 8'd156, 8'd110, 8'd72, 8'd42,
		8'd20, 8'd6};
	localparam logic [7:0] COS_DIV [COS_STEPS] = '{8'd240, 8'd182, 8'd132, 8'd90, 8'd56,
		8'd30, 8'd12, 8'd2};
	localparam logic [31:0] SIN_RCP [SIN_STEPS] = '{
		32'((64'd1 << 32) / 64'd210), 32'((64'd1 << 32) / 64'd156),
		32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
		32'((64'd1 << 32) / 64'd42), 32'((64'd1 << 32) / 64'd20),
		32'((64'd1 << 32) / 64'd6)};
	localparam logic [31:0] COS_RCP [COS_STEPS] = '{
		32'((64'd1 << 32) / 64'd240), 32'((64'd1 << 32) / 64'd182),
		32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
		32'((64'd1 << 32) / 64'd56), 32'((64'd1 << 32) / 64'd30),
		32'((64'd1 << 32) / 64'd12), 32'((64'd1 << 32) / 64'd2)};

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OVER    = 2'd1,
		ST_OUTSIDE = 2'd2
	} status_t;

	typedef enum logic {
		REG_TESS   = 1'b0,
		REG_RADIUS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] a0;
		logic [15:0] a1;
		logic [15:0] a2;
		logic [15:0] b2;
		logic        has_tri;
		status_t     st;
	} mesh_t;

	typedef struct packed {
		logic [8:0] rem;
		logic [3:0] bits;
	} dstep_t;

	// four restoring division steps, one quotient bit each
	function automatic dstep_t div_bits(input logic [8:0] rem, input logic [8:0] segs);
		logic [9:0] sh;
		dstep_t r;
		r.rem = rem;
		r.bits = '0;
		for (int b = 3; b >= 0; b--) begin
			sh = {r.rem, 1'b0};
			if (sh >= {1'b0, segs}) begin
				r.bits[b] = 1'b1;
				r.rem = 9'(sh - {1'b0, segs});
			end else begin
				r.rem = sh[8:0];
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/uvs_phase.sv -----
// Pipelined divider producing longitude and latitude phases.
module uvs_phase (
	input  logic                           clk,
	input  logic                           en,
	input  logic [7:0]                     ring,
	input  logic [8:0]                     column,
	input  logic [7:0]                     tess,
	output logic [uvs_pkg::PHASE_BITS-1:0] lon_phase,
	output logic [uvs_pkg::PHASE_BITS-1:0] lat_phase
);

	logic [8:0] segs;
	logic [8:0] num [2];
	logic [8:0] rem_s [uvs_pkg::DIV_STAGES][2];
	logic [15:0] q_s [uvs_pkg::DIV_STAGES][2];
	logic [8:0] rem_n [uvs_pkg::DIV_STAGES][2];
	logic [15:0] q_n [uvs_pkg::DIV_STAGES][2];

	assign segs = {tess, 1'b0};
	assign num[0] = column;
	assign num[1] = {1'b0, ring};

	always_comb begin
		uvs_pkg::dstep_t d;
		logic ge;
		logic [8:0] r0;
		for (int l = 0; l < 2; l++) begin
			ge = num[l] >= segs;
			r0 = ge ? 9'(num[l] - segs) : num[l];
			d = uvs_pkg::div_bits(r0, segs);
			rem_n[0][l] = d.rem;
			q_n[0][l] = {d.bits, 12'd0};
			for (int k = 1; k < uvs_pkg::DIV_STAGES; k++) begin
				d = uvs_pkg::div_bits(rem_s[k-1][l], segs);
				rem_n[k][l] = d.rem;
				q_n[k][l] = q_s[k-1][l] | 16'({12'd0, d.bits} << (12 - 4 * k));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < uvs_pkg::DIV_STAGES; k++) begin
				for (int l = 0; l < 2; l++) begin
					rem_s[k][l] <= rem_n[k][l];
					q_s[k][l] <= q_n[k][l];
				end
			end
		end
	end

	assign lon_phase = q_s[uvs_pkg::DIV_STAGES-1][0];
	assign lat_phase = q_s[uvs_pkg::DIV_STAGES-1][1] + uvs_pkg::LAT_OFS;

endmodule

// ----- rtl/uvs_hstep.sv -----
// One Horner step t' = 1 - (x2*t)/d in Q30, three register stages.
module uvs_hstep (
	input  logic        clk,
	input  logic        en,
	input  logic [29:0] x2_in,
	input  logic [30:0] t_in,
	input  logic [7:0]  div,
	input  logic [31:0] rcp,
	output logic [29:0] x2_out,
	output logic [30:0] t_out
);

	logic [29:0] v_s1, x2_s1, v_s2, x2_s2, x2_s3, qp;
	logic [29:0] qm_s2;
	logic [30:0] t_s3;
	logic [29:0] rem, q;

	assign qp = qm_s2;
	assign rem = 30'(v_s2 - 30'(38'(qp) * 38'(div)));
	assign q = (rem >= 30'(div)) ? 30'(qp + 30'd1) : qp;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= 30'((61'(x2_in) * 61'(t_in)) >> 30);
			x2_s1 <= x2_in;
			qm_s2 <= 30'((62'(v_s1) * 62'(rcp)) >> 32);
			v_s2 <= v_s1;
			x2_s2 <= x2_s1;
			t_s3 <= 31'(uvs_pkg::Q30_ONE - 31'(q));
			x2_s3 <= x2_s2;
		end
	end

	assign x2_out = x2_s3;
	assign t_out = t_s3;

endmodule

// ----- rtl/uvs_sincos.sv -----
// Pipelined Q1.15 sine and cosine of a turn phase.
module uvs_sincos (
	input  logic                           clk,
	input  logic                           en,
	input  logic [uvs_pkg::PHASE_BITS-1:0] phase,
	output logic signed [15:0]             sn,
	output logic signed [15:0]             cs
);

	logic [1:0] q_s1;
	logic swap_s1;
	logic [13:0] r_s1;
	logic [29:0] x_s2, x2_s3;
	logic [29:0] xd [uvs_pkg::X_DLY];
	logic [2:0] qd [uvs_pkg::Q_DLY];
	logic [30:0] s30_s25;
	logic [30:0] sd [uvs_pkg::S_DLY];
	logic [29:0] x2c [uvs_pkg::COS_STEPS+1];
	logic [30:0] tc [uvs_pkg::COS_STEPS+1];
	logic [29:0] x2s [uvs_pkg::SIN_STEPS+1];
	logic [30:0] ts [uvs_pkg::SIN_STEPS+1];
	logic [13:0] r_in;
	logic signed [15:0] sn_s28, cs_s28;
	logic signed [16:0] sn_n, cs_n;

	assign r_in = phase[13:0];
	assign x2c[0] = x2_s3;
	assign tc[0] = uvs_pkg::Q30_ONE;
	assign x2s[0] = x2_s3;
	assign ts[0] = uvs_pkg::Q30_ONE;

	for (genvar k = 0; k < uvs_pkg::COS_STEPS; k++) begin : g_cos
		uvs_hstep u_step (
			.clk(clk), .en(en), .x2_in(x2c[k]), .t_in(tc[k]),
			.div(uvs_pkg::COS_DIV[k]), .rcp(uvs_pkg::COS_RCP[k]),
			.x2_out(x2c[k+1]), .t_out(tc[k+1])
		);
	end

	for (genvar k = 0; k < uvs_pkg::SIN_STEPS; k++) begin : g_sin
		uvs_hstep u_step (
			.clk(clk), .en(en), .x2_in(x2s[k]), .t_in(ts[k]),
			.div(uvs_pkg::SIN_DIV[k]), .rcp(uvs_pkg::SIN_RCP[k]),
			.x2_out(x2s[k+1]), .t_out(ts[k+1])
		);
	end

	always_comb begin
		logic [30:0] sv, cv;
		logic [15:0] s0, c0;
		logic signed [16:0] se, ce;
		sv = qd[uvs_pkg::Q_DLY-1][0] ? tc[uvs_pkg::COS_STEPS] : sd[uvs_pkg::S_DLY-1];
		cv = qd[uvs_pkg::Q_DLY-1][0] ? sd[uvs_pkg::S_DLY-1] : tc[uvs_pkg::COS_STEPS];
		s0 = 16'((32'(sv) + 32'h4000) >> 15);
		c0 = 16'((32'(cv) + 32'h4000) >> 15);
		se = signed'({1'b0, s0});
		ce = signed'({1'b0, c0});
		unique case (qd[uvs_pkg::Q_DLY-1][2:1])
			2'd0: begin sn_n = se; cs_n = ce; end
			2'd1: begin sn_n = ce; cs_n = -se; end
			2'd2: begin sn_n = -se; cs_n = -ce; end
			default: begin sn_n = -ce; cs_n = se; end
		endcase
		if (sn_n > 17'sd32767) sn_n = 17'sd32767;
		if (cs_n > 17'sd32767) cs_n = 17'sd32767;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= phase[15:14];
			swap_s1 <= r_in > uvs_pkg::HALF;
			r_s1 <= (r_in > uvs_pkg::HALF) ? 14'(uvs_pkg::QUARTER - {1'b0, r_in}) : r_in;
			x_s2 <= 30'((45'(r_s1) * 45'(uvs_pkg::HALFPI_Q30) + 45'(uvs_pkg::HALF)) >> 14);
			x2_s3 <= 30'((60'(x_s2) * 60'(x_s2)) >> 30);
			xd[0] <= x_s2;
			for (int k = 1; k < uvs_pkg::X_DLY; k++) xd[k] <= xd[k-1];
			qd[0] <= {q_s1, swap_s1};
			for (int k = 1; k < uvs_pkg::Q_DLY; k++) qd[k] <= qd[k-1];
			s30_s25 <= 31'((61'(xd[uvs_pkg::X_DLY-1]) * 61'(ts[uvs_pkg::SIN_STEPS])) >> 30);
			sd[0] <= s30_s25;
			for (int k = 1; k < uvs_pkg::S_DLY; k++) sd[k] <= sd[k-1];
			sn_s28 <= sn_n[15:0];
			cs_s28 <= cs_n[15:0];
		end
	end

	assign sn = sn_s28;
	assign cs = cs_s28;

endmodule

// ----- rtl/uvs_scale.sv -----
// Vertex position: rotate and scale by the radius, two register stages.
module uvs_scale (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] slon,
	input  logic signed [15:0] clon,
	input  logic signed [15:0] slat,
	input  logic signed [15:0] clat,
	input  logic [15:0]        radius,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z
);

	logic signed [16:0] rad;
	logic signed [31:0] px, pz;
	logic signed [32:0] py;
	logic signed [33:0] qx, qz;
	logic signed [16:0] ax_s1, az_s1, y_s1, x_s2, y_s2, z_s2;

	assign rad = signed'({1'b0, radius});
	assign px = slon * clat;
	assign pz = clon * clat;
	assign py = 33'(slat) * 33'(rad);
	assign qx = 34'(ax_s1) * 34'(rad);
	assign qz = 34'(az_s1) * 34'(rad);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= 17'(px >>> 15);
			az_s1 <= 17'(pz >>> 15);
			y_s1 <= 17'(py >>> 15);
			x_s2 <= 17'(qx >>> 15);
			z_s2 <= 17'(qz >>> 15);
			y_s2 <= y_s1;
		end
	end

	assign pos_x = x_s2;
	assign pos_y = y_s2;
	assign pos_z = z_s2;

endmodule

// ----- rtl/uvs_index.sv -----
// Triangle indices, grid check and status, delayed to match the position path.
module uvs_index (
	input  logic                 clk,
	input  logic                 en,
	input  logic [7:0]           ring,
	input  logic [8:0]           column,
	input  logic [7:0]           tess,
	output uvs_pkg::mesh_t       mesh
);

	logic [9:0] stride, j1;
	logic bad;
	logic [17:0] base_s1;
	logic [9:0] stride_s1, nj_s1;
	logic [8:0] j_s1;
	logic bad_s1, below_s1;
	uvs_pkg::mesh_t m_n;
	uvs_pkg::mesh_t md [uvs_pkg::IDX_DLY];

	assign stride = 10'({tess, 1'b0}) + 10'd1;
	assign j1 = 10'(column) + 10'd1;
	assign bad = (tess < 8'(uvs_pkg::MIN_TESSELLATION))
		|| (9'(tess) > 9'(uvs_pkg::MAX_TESSELLATION))
		|| (ring > tess) || (column > {tess, 1'b0});

	always_comb begin
		logic [17:0] base1, i0, i1, i2, i5;
		logic over;
		base1 = base_s1 + 18'(stride_s1);
		i0 = base_s1 + 18'(j_s1);
		i1 = base1 + 18'(j_s1);
		i2 = base_s1 + 18'(nj_s1);
		i5 = base1 + 18'(nj_s1);
		over = (i0 >= 18'(uvs_pkg::INDEX_LIMIT)) || (i1 >= 18'(uvs_pkg::INDEX_LIMIT))
			|| (i2 >= 18'(uvs_pkg::INDEX_LIMIT)) || (i5 >= 18'(uvs_pkg::INDEX_LIMIT));
		m_n = '0;
		m_n.st = uvs_pkg::ST_OK;
		priority if (bad_s1) begin
			m_n.st = uvs_pkg::ST_OUTSIDE;
		end else if (!below_s1) begin
			m_n.st = uvs_pkg::ST_OK;
		end else if (over) begin
			m_n.st = uvs_pkg::ST_OVER;
		end else begin
			m_n.has_tri = 1'b1;
			m_n.a0 = i0[15:0];
			m_n.a1 = i1[15:0];
			m_n.a2 = i2[15:0];
			m_n.b2 = i5[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1 <= 18'(ring) * 18'(stride);
			stride_s1 <= stride;
			nj_s1 <= (j1 == stride) ? 10'd0 : j1;
			j_s1 <= column;
			bad_s1 <= bad;
			below_s1 <= ring < tess;
			md[0] <= m_n;
			for (int k = 1; k < uvs_pkg::IDX_DLY; k++) md[k] <= md[k-1];
		end
	end

	assign mesh = md[uvs_pkg::IDX_DLY-1];

endmodule

// ----- rtl/uv_sphere_point_generator.sv -----
// Top level of the UV sphere point generator.
// Input stream s_*: one grid point per transaction, tdata = {column, ring}.
// Output stream m_*: one vertex per transaction with position, the six
// triangle indices, has_triangles and status.
// Configuration: cfg_we/cfg_index/cfg_data write tessellation (index 0)
// and radius (index 1); write only while no point is in flight.
// Pipeline: 4 divider stages for the phases, 28 for sine/cosine (eight
// serial Horner steps of three stages each set this), 2 for the radius
// products, 1 output register.
// Throughput: one point per cycle while the receiver does not stall.
// Reset clears the valid bits and sets tessellation 3, radius 1.0.
// When the receiver stalls, the output register holds its transaction and
// the pipeline keeps accepting until its last stage is occupied; then the
// whole pipeline freezes and s_tready drops. Nothing is lost or repeated.
`include "uv_sphere_point_generator_macros.svh"
module uv_sphere_point_generator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,  // ring[7:0], column[16:8]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,  // pos_x, pos_y, pos_z, tri_a0, a1, a2, b0, b1, b2
	output logic [2:0]   m_tuser,  // has_triangles, status[1:0]
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);

	logic [7:0] tess_q;
	logic [15:0] radius_q;
	logic [uvs_pkg::CORE_LAT-1:0] v_s;
	logic adv, load, v_last;
	logic out_valid_q;
	logic [151:0] tdata_q;
	logic [2:0] user_q;
	logic [15:0] lon_phase, lat_phase;
	logic signed [15:0] slon, clon, slat, clat;
	logic signed [16:0] pos_x, pos_y, pos_z;
	uvs_pkg::mesh_t mesh;
	logic outside;

	assign v_last = v_s[uvs_pkg::CORE_LAT-1];
	assign load = !out_valid_q || m_tready;
	assign adv = load || !v_last;
	assign s_tready = adv;
	assign outside = mesh.st == uvs_pkg::ST_OUTSIDE;

	uvs_phase u_phase (
		.clk(clk), .en(adv), .ring(s_tdata[7:0]), .column(s_tdata[16:8]),
		.tess(tess_q), .lon_phase(lon_phase), .lat_phase(lat_phase)
	);

	uvs_sincos u_lon (.clk(clk), .en(adv), .phase(lon_phase), .sn(slon), .cs(clon));
	uvs_sincos u_lat (.clk(clk), .en(adv), .phase(lat_phase), .sn(slat), .cs(clat));

	uvs_scale u_scale (
		.clk(clk), .en(adv), .slon(slon), .clon(clon), .slat(slat), .clat(clat),
		.radius(radius_q), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
	);

	uvs_index u_index (
		.clk(clk), .en(adv), .ring(s_tdata[7:0]), .column(s_tdata[16:8]),
		.tess(tess_q), .mesh(mesh)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tess_q <= 8'd3;
			radius_q <= 16'd256;
		end else if (cfg_we) begin
			unique case (uvs_pkg::cfg_reg_t'(cfg_index))
				uvs_pkg::REG_TESS: tess_q <= cfg_data[7:0];
				uvs_pkg::REG_RADIUS: radius_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) v_s <= {v_s[uvs_pkg::CORE_LAT-2:0], s_tvalid};
			if (load) out_valid_q <= v_last;
		end
	end

	always_ff @(posedge clk) begin
		if (load && v_last) begin
			tdata_q <= {5'd0, mesh.b2, mesh.a1, mesh.a2, mesh.a2, mesh.a1, mesh.a0,
				outside ? 17'd0 : pos_z, outside ? 17'd0 : pos_y,
				outside ? 17'd0 : pos_x};
			user_q <= {mesh.st, mesh.has_tri};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = tdata_q;
	assign m_tuser = user_q;

	`UVS_ASSERT(a_accept_when_empty, !out_valid_q |-> s_tready)
	`UVS_ASSERT(a_tri_status_ok, out_valid_q && user_q[0] |-> user_q[2:1] == uvs_pkg::ST_OK)
	`UVS_ASSERT(a_outside_zero, out_valid_q && user_q[2:1] == uvs_pkg::ST_OUTSIDE |-> tdata_q == '0)
	`UVS_ASSERT(a_stall_freezes, !adv |=> v_s == $past(v_s))
	`UVS_ASSERT_RST(a_reset_empty, !arst_n |-> !m_tvalid)

endmodule
